@@ rtl/core/mme_pkg.sv @@
// ----------------------------------------------------------------------------
// mme_pkg
// shared widths, codes and types of the matrix multiply engine
// ----------------------------------------------------------------------------
package mme_pkg;

    localparam int MAX_DIM_DEF = 8;
    localparam int CFG_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int IDX_W       = 3;
    localparam int VAL_W       = 16;
    localparam int MUL_W       = 2 * VAL_W;
    localparam int PROD_W      = 35;
    localparam int KIND_W      = 2;

    typedef enum logic [KIND_W-1:0] {
        K_LOAD_LEFT  = 2'd0,
        K_LOAD_RIGHT = 2'd1,
        K_START      = 2'd2,
        K_UNUSED     = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_ROWS  = 2'd0,
        CFG_LEFT_COLS  = 2'd1,
        CFG_RIGHT_ROWS = 2'd2,
        CFG_RIGHT_COLS = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_HOLD
    } t_state;

    // control that travels with each multiply-accumulate step
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } t_mac_ctl;

endpackage

@@ rtl/core/mme_in_if.sv @@
// ----------------------------------------------------------------------------
// mme_in_if
// input channel: load and start transactions
// ----------------------------------------------------------------------------
interface mme_in_if;
    import mme_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, kind, row, col, value, input ready);
    modport sink   (input valid, kind, row, col, value, output ready);
endinterface

@@ rtl/core/mme_res_if.sv @@
// ----------------------------------------------------------------------------
// mme_res_if
// result channel: one product element per transaction
// ----------------------------------------------------------------------------
interface mme_res_if;
    import mme_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [PROD_W-1:0] product;
    logic                     last;

    modport source (output valid, ok, out_row, out_col, product, last, input ready);
    modport sink   (input valid, ok, out_row, out_col, product, last, output ready);
endinterface

@@ rtl/core/matrix_multiply_engine.sv @@
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// left and right matrix stores with a sequenced multiply-accumulate walk
// ----------------------------------------------------------------------------
// i_in carries loads (left or right element) and start transactions. a load
// writes the element into its store if it lies inside the configured size;
// otherwise it is dropped. a start checks left columns against right rows: on
// a mismatch one failure result goes out, otherwise every product element
// leaves on o_res in row-major order, last one marked. each element reads one
// left and one right entry per cycle from the two stores and passes through
// read, multiply, accumulate and hand-over steps. i_in is taken only while no
// multiply is running. results pass through an output register: the next
// element is computed while one waits, and the walk pauses when the receiver
// stalls with a finished element pending. reset sets all sizes to 8 and empties
// the output; the stores are not cleared and must be loaded before use. the
// user must write sizes (i_cfg_*) only between transactions; the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
module matrix_multiply_engine #(
    parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mme_pkg::CFG_W-1:0]        i_cfg_data,
    mme_in_if.sink                           i_in,
    mme_res_if.source                        o_res
);
    import mme_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int DLIM  = (MAX_DIM < (1 << IDX_W)) ? MAX_DIM : (1 << IDX_W);

    function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] d;
        d = v;
        if (v == '0) begin
            d = CFG_W'(1);
        end else if (v > CFG_W'(DLIM)) begin
            d = CFG_W'(DLIM);
        end
        return d;
    endfunction

    // configuration
    logic [CFG_W-1:0] r_lrows, r_lcols, r_rrows, r_rcols;
    logic [CFG_W-1:0] w_lr, w_lc, w_rr, w_rc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lrows <= CFG_W'(8);
            r_lcols <= CFG_W'(8);
            r_rrows <= CFG_W'(8);
            r_rcols <= CFG_W'(8);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LEFT_ROWS:  r_lrows <= i_cfg_data;
                CFG_LEFT_COLS:  r_lcols <= i_cfg_data;
                CFG_RIGHT_ROWS: r_rrows <= i_cfg_data;
                CFG_RIGHT_COLS: r_rcols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_lr = eff_dim(r_lrows);
    assign w_lc = eff_dim(r_lcols);
    assign w_rr = eff_dim(r_rrows);
    assign w_rc = eff_dim(r_rcols);

    // sequencer state
    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_r, n_r, r_c, n_c, r_k, n_k;
    logic               r_ovld, n_ovld;
    logic               r_res_ok, n_res_ok;
    logic               r_res_last, n_res_last;
    logic [IDX_W-1:0]   r_res_row, n_res_row, r_res_col, n_res_col;
    logic signed [PROD_W-1:0] r_res_prod, n_res_prod;
    logic               r_o_ok, r_o_last;
    logic [IDX_W-1:0]   r_o_row, r_o_col;
    logic signed [PROD_W-1:0] r_o_prod;

    logic               w_accept, w_out_free, w_load_out;
    logic               w_k_last, w_c_last, w_r_last;
    logic               w_lwe, w_rwe;
    logic [AW-1:0]      w_waddr, w_laddr, w_raddr;
    t_mac_ctl           w_issue, r_rd_ctl;

    logic [VAL_W-1:0]   r_lmem [DEPTH];
    logic [VAL_W-1:0]   r_rmem [DEPTH];
    logic [VAL_W-1:0]   r_lq, r_rq;
    logic               w_mac_done;
    logic signed [PROD_W-1:0] w_mac_acc;

    assign w_accept   = i_in.valid & i_in.ready;
    assign w_out_free = ~r_ovld | o_res.ready;
    assign w_k_last   = {1'b0, r_k} == (w_lc - CFG_W'(1));
    assign w_c_last   = {1'b0, r_c} == (w_rc - CFG_W'(1));
    assign w_r_last   = {1'b0, r_r} == (w_lr - CFG_W'(1));

    assign w_waddr = AW'(i_in.row) * AW'(MAX_DIM) + AW'(i_in.col);
    assign w_laddr = AW'(r_r) * AW'(MAX_DIM) + AW'(r_k);
    assign w_raddr = AW'(r_k) * AW'(MAX_DIM) + AW'(r_c);

    always_comb begin
        n_state    = r_state;
        n_r        = r_r;
        n_c        = r_c;
        n_k        = r_k;
        n_res_ok   = r_res_ok;
        n_res_last = r_res_last;
        n_res_row  = r_res_row;
        n_res_col  = r_res_col;
        n_res_prod = r_res_prod;
        w_lwe      = 1'b0;
        w_rwe      = 1'b0;
        w_issue    = '0;
        w_load_out = 1'b0;
        i_in.ready = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (t_kind'(i_in.kind))
                        K_LOAD_LEFT: begin
                            w_lwe = ({1'b0, i_in.row} < w_lr) && ({1'b0, i_in.col} < w_lc);
                        end
                        K_LOAD_RIGHT: begin
                            w_rwe = ({1'b0, i_in.row} < w_rr) && ({1'b0, i_in.col} < w_rc);
                        end
                        K_START: begin
                            n_r = '0;
                            n_c = '0;
                            n_k = '0;
                            if (w_lc != w_rr) begin
                                n_res_ok   = 1'b0;
                                n_res_last = 1'b1;
                                n_res_row  = '0;
                                n_res_col  = '0;
                                n_res_prod = '0;
                                n_state    = S_HOLD;
                            end else begin
                                n_state = S_RUN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RUN: begin
                w_issue.vld   = 1'b1;
                w_issue.first = (r_k == '0);
                w_issue.last  = w_k_last;
                if (w_k_last) begin
                    n_k     = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                if (w_mac_done) begin
                    n_res_ok   = 1'b1;
                    n_res_row  = r_r;
                    n_res_col  = r_c;
                    n_res_prod = w_mac_acc;
                    n_res_last = w_r_last & w_c_last;
                    n_state    = S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    if (r_res_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_RUN;
                        if (w_c_last) begin
                            n_c = '0;
                            n_r = r_r + IDX_W'(1);
                        end else begin
                            n_c = r_c + IDX_W'(1);
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (w_load_out) begin
            n_ovld = 1'b1;
        end else if (o_res.ready) begin
            n_ovld = 1'b0;
        end else begin
            n_ovld = r_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovld   <= 1'b0;
            r_rd_ctl <= '0;
        end else begin
            r_state  <= n_state;
            r_ovld   <= n_ovld;
            r_rd_ctl <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r        <= n_r;
        r_c        <= n_c;
        r_k        <= n_k;
        r_res_ok   <= n_res_ok;
        r_res_last <= n_res_last;
        r_res_row  <= n_res_row;
        r_res_col  <= n_res_col;
        r_res_prod <= n_res_prod;
        if (w_load_out) begin
            r_o_ok   <= r_res_ok;
            r_o_last <= r_res_last;
            r_o_row  <= r_res_row;
            r_o_col  <= r_res_col;
            r_o_prod <= r_res_prod;
        end
    end

    // element stores
    always_ff @(posedge i_clk) begin
        if (w_lwe) begin
            r_lmem[w_waddr] <= i_in.value;
        end
        r_lq <= r_lmem[w_laddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_rwe) begin
            r_rmem[w_waddr] <= i_in.value;
        end
        r_rq <= r_rmem[w_raddr];
    end

    mme_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_rd_ctl),
        .i_a     (r_lq),
        .i_b     (r_rq),
        .o_done  (w_mac_done),
        .o_acc   (w_mac_acc)
    );

    assign o_res.valid   = r_ovld;
    assign o_res.ok      = r_o_ok;
    assign o_res.out_row = r_o_row;
    assign o_res.out_col = r_o_col;
    assign o_res.product = r_o_prod;
    assign o_res.last    = r_o_last;
endmodule

@@ rtl/core/mme_mac.sv @@
// ----------------------------------------------------------------------------
// mme_mac
// two-stage multiply-accumulate: registered product, then running sum
// ----------------------------------------------------------------------------
module mme_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mme_pkg::t_mac_ctl                 i_ctl,
    input  logic [mme_pkg::VAL_W-1:0]         i_a,
    input  logic [mme_pkg::VAL_W-1:0]         i_b,
    output logic                              o_done,
    output logic signed [mme_pkg::PROD_W-1:0] o_acc
);
    import mme_pkg::*;

    t_mac_ctl                r_mul_ctl;
    logic signed [MUL_W-1:0] r_mul;
    logic signed [PROD_W-1:0] r_acc;
    logic                    r_done;
    logic signed [PROD_W-1:0] w_mul_ext;

    assign w_mul_ext = {{(PROD_W-MUL_W){r_mul[MUL_W-1]}}, r_mul};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_ctl <= '0;
            r_done    <= 1'b0;
        end else begin
            r_mul_ctl <= i_ctl;
            r_done    <= r_mul_ctl.vld & r_mul_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mul <= signed'(i_a) * signed'(i_b);
        if (r_mul_ctl.vld) begin
            r_acc <= r_mul_ctl.first ? w_mul_ext : r_acc + w_mul_ext;
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;
endmodule

@@ tb/sv/matrix_multiply_engine_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_multiply_engine_test
// self-checking bench for the matrix multiply engine. a short table of loads
// and starts covers value extremes, dropped loads, the unused kind and size
// mismatches; random phases follow, each with its own size setting. every
// product element is checked against an in-bench model of the two stores.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_test;
    import mme_pkg::*;

    localparam int DIM        = MAX_DIM_DEF;
    localparam int SETTLE_CYC = 16;
    localparam int IDLE_LIMIT = 2000;
    localparam int RAND_ITEMS = 140;

    typedef struct packed {
        bit                       ok;
        bit [IDX_W-1:0]           row;
        bit [IDX_W-1:0]           col;
        logic signed [PROD_W-1:0] product;
        bit                       last;
    } prod_elem_t;

    typedef struct packed {
        bit                       set_size;
        bit [3:0][CFG_W-1:0]      size;
        t_kind                    kind;
        bit [IDX_W-1:0]           row;
        bit [IDX_W-1:0]           col;
        logic signed [VAL_W-1:0]  value;
        bit                       typed;
        prod_elem_t               elem;
    } stim_row_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    mme_in_if  in_ch ();
    mme_res_if res_ch ();

    matrix_multiply_engine #(
        .MAX_DIM    (DIM)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_res      (res_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // model of the engine: size registers and both stores
    bit [CFG_W-1:0]          size_reg  [4];
    logic signed [VAL_W-1:0] left_mem  [DIM*DIM];
    logic signed [VAL_W-1:0] right_mem [DIM*DIM];
    bit                      left_set  [DIM*DIM];
    bit                      right_set [DIM*DIM];
    prod_elem_t              pending_elems [$];
    stim_row_t               dir_rows [$];

    int errors;
    int burst_left;
    int idle_cycles = 0;
    int stall_left  = 0;
    int stall_mode  = 0;
    int mode_left   = 0;

    function automatic int eff_dim(bit [CFG_W-1:0] raw);
        int d;
        d = int'(raw);
        if (d < 1) d = 1;
        if (d > DIM) d = DIM;
        return d;
    endfunction

    function automatic void predict(t_kind kd, bit [IDX_W-1:0] r, bit [IDX_W-1:0] c,
                                    logic signed [VAL_W-1:0] v, bit push);
        int         lr, lc, rr, rc;
        longint     acc;
        prod_elem_t e;
        lr = eff_dim(size_reg[CFG_LEFT_ROWS]);
        lc = eff_dim(size_reg[CFG_LEFT_COLS]);
        rr = eff_dim(size_reg[CFG_RIGHT_ROWS]);
        rc = eff_dim(size_reg[CFG_RIGHT_COLS]);
        case (kd)
            K_LOAD_LEFT: begin
                if (r < lr && c < lc) begin
                    left_mem[r*DIM+c] = v;
                    left_set[r*DIM+c] = 1'b1;
                end
            end
            K_LOAD_RIGHT: begin
                if (r < rr && c < rc) begin
                    right_mem[r*DIM+c] = v;
                    right_set[r*DIM+c] = 1'b1;
                end
            end
            K_START: begin
                if (push && lc != rr) begin
                    e = '0;
                    e.last = 1'b1;
                    pending_elems.push_back(e);
                end else if (push) begin
                    for (int i = 0; i < lr; i++) begin
                        for (int j = 0; j < rc; j++) begin
                            acc = 0;
                            for (int m = 0; m < lc; m++)
                                acc += longint'(left_mem[i*DIM+m]) *
                                       longint'(right_mem[m*DIM+j]);
                            e.ok      = 1'b1;
                            e.row     = IDX_W'(i);
                            e.col     = IDX_W'(j);
                            e.product = acc[PROD_W-1:0];
                            e.last    = (i == lr - 1) && (j == rc - 1);
                            pending_elems.push_back(e);
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // a start may only go out once every entry it reads has been loaded
    function automatic bit start_safe();
        int lr, lc, rr, rc;
        lr = eff_dim(size_reg[CFG_LEFT_ROWS]);
        lc = eff_dim(size_reg[CFG_LEFT_COLS]);
        rr = eff_dim(size_reg[CFG_RIGHT_ROWS]);
        rc = eff_dim(size_reg[CFG_RIGHT_COLS]);
        if (lc != rr) return 1'b1;
        for (int i = 0; i < lr; i++)
            for (int m = 0; m < lc; m++)
                if (!left_set[i*DIM+m]) return 1'b0;
        for (int m = 0; m < rr; m++)
            for (int j = 0; j < rc; j++)
                if (!right_set[m*DIM+j]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic stim_row_t stim(t_kind kd, int r, int c, logic signed [VAL_W-1:0] v);
        stim_row_t s;
        s       = '0;
        s.kind  = kd;
        s.row   = IDX_W'(r);
        s.col   = IDX_W'(c);
        s.value = v;
        return s;
    endfunction

    function automatic stim_row_t resized(stim_row_t s, int lr, int lc, int rr, int rc);
        s.set_size             = 1'b1;
        s.size[CFG_LEFT_ROWS]  = CFG_W'(lr);
        s.size[CFG_LEFT_COLS]  = CFG_W'(lc);
        s.size[CFG_RIGHT_ROWS] = CFG_W'(rr);
        s.size[CFG_RIGHT_COLS] = CFG_W'(rc);
        return s;
    endfunction

    // the single result of a 1x1 product or of a size mismatch
    function automatic stim_row_t answered(stim_row_t s, bit ok, logic signed [PROD_W-1:0] p);
        s.typed        = 1'b1;
        s.elem         = '0;
        s.elem.ok      = ok;
        s.elem.product = p;
        s.elem.last    = 1'b1;
        return s;
    endfunction

    function automatic bit [CFG_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return CFG_W'($urandom_range(9, 15));
        if (r <= 3) return CFG_W'(DIM);
        return CFG_W'($urandom_range(1, 3));
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return '0;
            default: return VAL_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t ns mismatch: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_field(string name, logic signed [PROD_W-1:0] got,
                               logic signed [PROD_W-1:0] want, prod_elem_t ref_elem);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, expected %0d (element r%0d c%0d)",
                                      name, got, want, ref_elem.row, ref_elem.col));
    endtask

    // one transaction on i_in; the sender pauses between bursts
    task automatic send_item(stim_row_t s);
        in_ch.valid <= 1'b1;
        in_ch.kind  <= s.kind;
        in_ch.row   <= s.row;
        in_ch.col   <= s.col;
        in_ch.value <= s.value;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict(s.kind, s.row, s.col, s.value, !s.typed);
        if (s.typed) pending_elems.push_back(s.elem);
        burst_left--;
        if (burst_left <= 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
        end
    endtask

    // sizes change only once the engine has drained
    task automatic apply_sizes(bit [3:0][CFG_W-1:0] sz);
        in_ch.valid <= 1'b0;
        while (pending_elems.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= t_cfg_idx'(i);
            i_cfg_data  <= sz[i];
            size_reg[i]  = sz[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // result checking and receiver stall pattern
    always @(posedge i_clk) begin
        prod_elem_t want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_elems.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending at r%0d c%0d",
                                          res_ch.out_row, res_ch.out_col));
            end else begin
                want = pending_elems.pop_front();
                check_field("ok", PROD_W'(res_ch.ok), PROD_W'(want.ok), want);
                check_field("out_row", PROD_W'(res_ch.out_row), PROD_W'(want.row), want);
                check_field("out_col", PROD_W'(res_ch.out_col), PROD_W'(want.col), want);
                check_field("product", res_ch.product, want.product, want);
                check_field("last", PROD_W'(res_ch.last), PROD_W'(want.last), want);
            end
        end
        if (stall_left > 0) begin
            res_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            res_ch.ready <= 1'b1;
            case (stall_mode)
                1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
                2: if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(4, 12);
                default: ;
            endcase
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 100);
        end else begin
            mode_left--;
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("matrix_multiply_engine_test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        stim_row_t           s;
        stim_row_t           loads [$];
        bit [3:0][CFG_W-1:0] sz;
        int                  lr, lc, rr, rc;
        int                  phase;
        int                  rand_count;
        int                  m;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        in_ch.valid  = 1'b0;
        in_ch.kind   = K_LOAD_LEFT;
        in_ch.row    = '0;
        in_ch.col    = '0;
        in_ch.value  = '0;
        res_ch.ready = 1'b0;
        errors       = 0;
        burst_left   = $urandom_range(1, 6);
        for (int i = 0; i < 4; i++) size_reg[i] = CFG_W'(DIM);
        for (int i = 0; i < DIM*DIM; i++) begin
            left_set[i]  = 1'b0;
            right_set[i] = 1'b0;
            left_mem[i]  = '0;
            right_mem[i] = '0;
        end

        // extremes of the Q8.8 range on the smallest size
        dir_rows.push_back(resized(stim(K_LOAD_LEFT, 0, 0, 16'sh8000), 1, 1, 1, 1));
        dir_rows.push_back(stim(K_LOAD_RIGHT, 0, 0, 16'sh8000));
        dir_rows.push_back(answered(stim(K_START, 0, 0, '0), 1'b1, 35'sd1073741824));
        dir_rows.push_back(stim(K_LOAD_LEFT, 0, 0, 16'sh7fff));
        dir_rows.push_back(answered(stim(K_START, 0, 0, '0), 1'b1, -35'sd1073709056));
        dir_rows.push_back(stim(K_LOAD_RIGHT, 0, 0, 16'sh7fff));
        dir_rows.push_back(answered(stim(K_START, 0, 0, '0), 1'b1, 35'sd1073676289));
        // loads outside the size and the unused kind leave the stores alone
        dir_rows.push_back(stim(K_LOAD_LEFT, 7, 7, 16'sh0000));
        dir_rows.push_back(stim(K_LOAD_RIGHT, 0, 1, 16'shffff));
        dir_rows.push_back(stim(K_UNUSED, 7, 7, 16'shffff));
        dir_rows.push_back(answered(stim(K_START, 0, 0, '0), 1'b1, 35'sd1073676289));
        // inner sizes disagree, the second with out-of-range register values
        dir_rows.push_back(answered(resized(stim(K_START, 0, 0, '0), 1, 2, 1, 1), 1'b0, '0));
        dir_rows.push_back(answered(resized(stim(K_START, 0, 0, '0), 15, 0, 9, 3), 1'b0, '0));
        // full 2x2 product
        dir_rows.push_back(resized(stim(K_LOAD_LEFT, 0, 0, 16'sh7fff), 2, 2, 2, 2));
        dir_rows.push_back(stim(K_LOAD_LEFT, 0, 1, 16'sh8000));
        dir_rows.push_back(stim(K_LOAD_LEFT, 1, 0, 16'shffff));
        dir_rows.push_back(stim(K_LOAD_LEFT, 1, 1, 16'sh0001));
        dir_rows.push_back(stim(K_LOAD_RIGHT, 0, 0, 16'sh0100));
        dir_rows.push_back(stim(K_LOAD_RIGHT, 0, 1, 16'sh8000));
        dir_rows.push_back(stim(K_LOAD_RIGHT, 1, 0, 16'sh7fff));
        dir_rows.push_back(stim(K_LOAD_RIGHT, 1, 1, 16'shff00));
        dir_rows.push_back(stim(K_START, 0, 0, '0));
        // zero in every register saturates to a 1x1 product
        dir_rows.push_back(resized(stim(K_START, 0, 0, '0), 0, 0, 0, 0));
        // far corner of the largest size
        dir_rows.push_back(resized(stim(K_LOAD_LEFT, 7, 7, 16'sh5555), 8, 8, 8, 8));
        dir_rows.push_back(stim(K_LOAD_RIGHT, 7, 7, 16'shaaaa));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[n]) begin
            if (dir_rows[n].set_size) apply_sizes(dir_rows[n].size);
            send_item(dir_rows[n]);
        end

        phase      = 0;
        rand_count = 0;
        while (rand_count < RAND_ITEMS) begin
            case (phase)
                // tall times wide: the most results per start
                0: begin
                    sz[CFG_LEFT_ROWS]  = CFG_W'(DIM);
                    sz[CFG_LEFT_COLS]  = 4'd1;
                    sz[CFG_RIGHT_ROWS] = 4'd1;
                    sz[CFG_RIGHT_COLS] = CFG_W'(DIM);
                end
                // wide times tall: the longest inner sum
                1: begin
                    sz[CFG_LEFT_ROWS]  = 4'd1;
                    sz[CFG_LEFT_COLS]  = CFG_W'(DIM);
                    sz[CFG_RIGHT_ROWS] = CFG_W'(DIM);
                    sz[CFG_RIGHT_COLS] = 4'd1;
                end
                default: begin
                    sz[CFG_LEFT_ROWS]  = pick_size();
                    sz[CFG_LEFT_COLS]  = pick_size();
                    sz[CFG_RIGHT_ROWS] = ($urandom_range(0, 6) == 0) ? pick_size()
                                                                     : sz[CFG_LEFT_COLS];
                    sz[CFG_RIGHT_COLS] = pick_size();
                end
            endcase
            apply_sizes(sz);
            lr = eff_dim(size_reg[CFG_LEFT_ROWS]);
            lc = eff_dim(size_reg[CFG_LEFT_COLS]);
            rr = eff_dim(size_reg[CFG_RIGHT_ROWS]);
            rc = eff_dim(size_reg[CFG_RIGHT_COLS]);
            repeat ($urandom_range(1, 2)) begin
                // every unloaded entry plus a random share of reloads
                loads.delete();
                for (int i = 0; i < lr; i++)
                    for (int j = 0; j < lc; j++)
                        if (!left_set[i*DIM+j] || $urandom_range(0, 2) == 0)
                            loads.push_back(stim(K_LOAD_LEFT, i, j, rand_value()));
                for (int i = 0; i < rr; i++)
                    for (int j = 0; j < rc; j++)
                        if (!right_set[i*DIM+j] || $urandom_range(0, 2) == 0)
                            loads.push_back(stim(K_LOAD_RIGHT, i, j, rand_value()));
                for (int n = loads.size() - 1; n > 0; n--) begin
                    m        = $urandom_range(0, n);
                    s        = loads[n];
                    loads[n] = loads[m];
                    loads[m] = s;
                end
                foreach (loads[n]) begin
                    if ($urandom_range(0, 7) == 0) begin
                        s = stim(t_kind'($urandom_range(0, 3)), $urandom_range(0, 7),
                                 $urandom_range(0, 7), rand_value());
                        if (s.kind == K_START) s.kind = K_UNUSED;
                        send_item(s);
                        if (s.kind != K_UNUSED) rand_count++;
                    end
                    // early start in the middle of a reload
                    if ($urandom_range(0, 15) == 0 && start_safe()) begin
                        send_item(stim(K_START, 0, 0, rand_value()));
                        rand_count++;
                    end
                    send_item(loads[n]);
                    rand_count++;
                end
                send_item(stim(K_START, $urandom_range(0, 7), $urandom_range(0, 7),
                               rand_value()));
                rand_count++;
            end
            phase++;
        end

        in_ch.valid <= 1'b0;
        while (pending_elems.size() != 0) @(posedge i_clk);
        repeat (2 * SETTLE_CYC) @(posedge i_clk);
        if (errors == 0)
            $display("matrix_multiply_engine_test passed");
        else
            $display("matrix_multiply_engine_test failed");
        $finish;
    end

endmodule
